### rtl/core/shl_pkg.sv
// Package for the spatial hash cell lookup: sizes, field widths, opcodes,
// register indexes, transaction payloads and internal entry structs.
// No dependencies; every other file of the block uses it.
package shl_pkg;

	localparam int HASH_DEPTH = 1024;
	localparam int CELL_DEPTH = 4096;
	localparam int HASH_AW    = $clog2(HASH_DEPTH);
	localparam int CELL_AW    = $clog2(CELL_DEPTH);
	localparam int MOD_W      = HASH_AW + 1;
	localparam int SLOT_W     = CELL_AW + 1;

	localparam int OPC_W      = 2;
	localparam int TIDX_W     = 12;
	localparam int BFIRST_W   = 12;
	localparam int BSIZE_W    = 13;
	localparam int KEY_W      = 31;
	localparam int PART_W     = 20;
	localparam int COORD_W    = 16;
	localparam int RANGE_W    = 21;
	localparam int CPR_W      = 16;
	localparam int HLEN_W     = 11;
	localparam int BKT_SUM_W  = BSIZE_W + 1;

	// Bucket hash 3x + 5y on 15-bit coordinates fits in 18 bits.
	localparam int HASH_MUL_X = 3;
	localparam int HASH_MUL_Y = 5;
	localparam int HASH_DIV_W = 18;
	localparam int MOD_STEP_BITS = 3;
	localparam int MOD_STEPS  = HASH_DIV_W / MOD_STEP_BITS;
	localparam int MOD_CNT_W  = $clog2(MOD_STEPS + 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_PER_ROW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HASH_LENGTH   = 2'd1;
	localparam logic [CPR_W-1:0]  CPR_RESET  = 16'd1;
	localparam logic [HLEN_W-1:0] HLEN_RESET = 11'd1024;

	localparam logic [OPC_W-1:0] OP_WR_BUCKET = 2'd0;
	localparam logic [OPC_W-1:0] OP_WR_CELL   = 2'd1;
	localparam logic [OPC_W-1:0] OP_QUERY     = 2'd2;
	localparam logic [OPC_W-1:0] OP_NOP       = 2'd3;

	typedef struct packed {
		logic [OPC_W-1:0]          opcode;
		logic [TIDX_W-1:0]         table_index;
		logic                      bucket_empty;
		logic [BFIRST_W-1:0]       bucket_first;
		logic [BSIZE_W-1:0]        bucket_size;
		logic [KEY_W-1:0]          cell_number;
		logic [PART_W-1:0]         cell_first_particle;
		logic [PART_W-1:0]         cell_particle_count;
		logic signed [COORD_W-1:0] query_x;
		logic signed [COORD_W-1:0] query_y;
	} in_item_t;

	typedef struct packed {
		logic               found;
		logic [RANGE_W-1:0] range_begin;
		logic [RANGE_W-1:0] range_end;
	} out_item_t;

	localparam out_item_t MISS_RESULT = '0;

	typedef struct packed {
		logic                empty;
		logic [BFIRST_W-1:0] first;
		logic [BSIZE_W-1:0]  size;
	} bucket_entry_t;

	localparam bucket_entry_t BUCKET_CLEARED = '{empty: 1'b1, first: '0, size: '0};

	typedef struct packed {
		logic               en;
		logic [HASH_AW-1:0] addr;
		bucket_entry_t      entry;
	} bucket_wr_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [PART_W-1:0] first;
		logic [PART_W-1:0] count;
	} cell_entry_t;

	typedef struct packed {
		logic               en;
		logic [CELL_AW-1:0] addr;
		cell_entry_t        entry;
	} cell_wr_t;

	typedef struct packed {
		logic               done;
		logic [HASH_AW-1:0] rem;
	} mod_res_t;

endpackage

### rtl/core/shl_if.sv
// Valid/ready channel interfaces for the command and response transactions.
// Depends on shl_pkg for the payload types.
interface shl_cmd_if;
	logic              valid;
	logic              ready;
	shl_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface shl_rsp_if;
	logic               valid;
	logic               ready;
	shl_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/shl_hash_mod.sv
// Iterative remainder unit: dividend mod modulus, MOD_STEP_BITS bits per cycle.
// Depends on shl_pkg for widths and the result struct.
module shl_hash_mod (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [shl_pkg::HASH_DIV_W-1:0]   dividend,
	input  logic [shl_pkg::MOD_W-1:0]        modulus,
	output shl_pkg::mod_res_t                res
);
	import shl_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [MOD_CNT_W-1:0]  cnt_q;
	logic [HASH_DIV_W-1:0] dvd_q;
	logic [MOD_W-1:0]      mod_q;
	logic [HASH_AW-1:0]    rem_q;
	logic [HASH_AW-1:0]    rem_next;

	// Restoring remainder, MOD_STEP_BITS dividend bits per cycle.
	always_comb begin
		logic [MOD_W-1:0] trial;
		logic [HASH_AW-1:0] r;
		r = rem_q;
		for (int i = 0; i < MOD_STEP_BITS; i++) begin
			trial = {r, dvd_q[HASH_DIV_W-1-i]};
			if (trial >= mod_q) begin
				trial = trial - mod_q;
			end
			r = trial[HASH_AW-1:0];
		end
		rem_next = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= MOD_CNT_W'(MOD_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - MOD_CNT_W'(1);
				if (cnt_q == MOD_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			mod_q <= modulus;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << MOD_STEP_BITS;
			rem_q <= rem_next;
		end
	end

	assign res.done = done_q;
	assign res.rem  = rem_q;

endmodule

### rtl/core/shl_bucket_store.sv
// Bucket table memory with a clearing pass after reset that marks every
// bucket empty. Depends on shl_pkg for the entry and write structs.
module shl_bucket_store (
	input  logic                         clk,
	input  logic                         arst_n,
	input  shl_pkg::bucket_wr_t          wr,
	input  logic                         rd_en,
	input  logic [shl_pkg::HASH_AW-1:0]  rd_addr,
	output shl_pkg::bucket_entry_t       rd_data,
	output logic                         clearing
);
	import shl_pkg::*;

	bucket_entry_t       mem [HASH_DEPTH];
	logic [HASH_AW:0]    clr_q;

	assign clearing = (clr_q != (HASH_AW + 1)'(HASH_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clearing) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing) begin
			mem[clr_q[HASH_AW-1:0]] <= BUCKET_CLEARED;
		end else if (wr.en) begin
			mem[wr.addr] <= wr.entry;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/core/shl_cell_store.sv
// Cell table memory: key, first particle and particle count per slot.
// Depends on shl_pkg for the entry and write structs.
module shl_cell_store (
	input  logic                         clk,
	input  shl_pkg::cell_wr_t            wr,
	input  logic                         rd_en,
	input  logic [shl_pkg::CELL_AW-1:0]  rd_addr,
	output shl_pkg::cell_entry_t         rd_data
);
	import shl_pkg::*;

	cell_entry_t mem [CELL_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.entry;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/core/spatial_hash_cell_lookup.sv
// Top level of the spatial hash cell lookup: command sequencer, config
// registers and output register. Depends on shl_pkg, shl_if, shl_hash_mod,
// shl_bucket_store and shl_cell_store.
//
//   channel  direction  handshake          payload
//   cmd      in         valid / ready      shl_pkg::in_item_t
//   rsp      out        valid / ready      shl_pkg::out_item_t
//   cfg      in         cfg_we (no ready)  cfg_index, cfg_data
//
// A bucket or cell write lands in memory at the edge that accepts it. A
// query runs from acceptance through the remainder unit for the bucket
// hash, one bucket read, then a scan of the cell slots, one slot per
// cycle through the cell memory read port, to a valid response.
// After reset the bucket memory is swept once, one bucket per cycle,
// and cmd.ready stays low until it is done.
// A finished response waits in the output register; new commands are taken
// meanwhile, and a later query holds in its final state until the register
// is free.
module spatial_hash_cell_lookup (
	input  logic                             clk,
	input  logic                             arst_n,
	shl_cmd_if.sink                          cmd,
	shl_rsp_if.source                        rsp,
	input  logic                             cfg_we,
	input  logic [shl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [shl_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import shl_pkg::*;

	// Sequencer states.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_HASH = 3'd1;
	localparam logic [2:0] ST_BKT  = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]        state_q;
	logic [2:0]        state_d;

	logic [CPR_W-1:0]  cpr_q;
	logic [HLEN_W-1:0] hlen_q;

	logic [KEY_W-1:0]  key_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] stop_q;
	out_item_t         res_q;
	out_item_t         out_q;
	logic              out_valid_q;

	logic              cmd_fire;
	logic              clearing;
	logic              q_neg;
	logic [COORD_W-2:0] q_x;
	logic [COORD_W-2:0] q_y;
	logic [KEY_W-1:0]  key_d;
	logic [HASH_DIV_W-1:0] hash_sum;
	logic [MOD_W-1:0]  modulus;
	logic              mod_start;
	mod_res_t          mod_res;

	bucket_wr_t        bkt_wr;
	bucket_entry_t     bkt_rd;
	cell_wr_t          cell_wr;
	cell_entry_t       cell_rd;
	logic              cell_rd_en;
	logic [CELL_AW-1:0] cell_rd_addr;

	logic [SLOT_W-1:0]    bkt_first;
	logic [BKT_SUM_W-1:0] bkt_sum;
	logic [SLOT_W-1:0]    bkt_stop;
	logic [SLOT_W-1:0]    slot_next;
	logic                 cell_hit;
	logic                 emit_load;

	// Command side handshake. Commands are taken only between queries.
	assign cmd.ready = (state_q == ST_IDLE) && !clearing;
	assign cmd_fire  = cmd.valid && cmd.ready;

	// Table writes go straight into the memories at acceptance; a write
	// beyond a table's depth is dropped.
	assign bkt_wr.en = cmd_fire && (cmd.data.opcode == OP_WR_BUCKET)
		&& (32'(cmd.data.table_index) < HASH_DEPTH);
	assign bkt_wr.addr        = HASH_AW'(cmd.data.table_index);
	assign bkt_wr.entry.empty = cmd.data.bucket_empty;
	assign bkt_wr.entry.first = cmd.data.bucket_first;
	assign bkt_wr.entry.size  = cmd.data.bucket_size;

	assign cell_wr.en = cmd_fire && (cmd.data.opcode == OP_WR_CELL)
		&& (32'(cmd.data.table_index) < CELL_DEPTH);
	assign cell_wr.addr        = CELL_AW'(cmd.data.table_index);
	assign cell_wr.entry.key   = cmd.data.cell_number;
	assign cell_wr.entry.first = cmd.data.cell_first_particle;
	assign cell_wr.entry.count = cmd.data.cell_particle_count;

	// Query front end: a negative coordinate misses at once. Otherwise the
	// linear key is formed here and registered, and the bucket hash is
	// handed to the remainder unit.
	assign q_neg = cmd.data.query_x[COORD_W-1] || cmd.data.query_y[COORD_W-1];
	assign q_x   = cmd.data.query_x[COORD_W-2:0];
	assign q_y   = cmd.data.query_y[COORD_W-2:0];
	assign key_d = KEY_W'(cpr_q) * KEY_W'(q_y) + KEY_W'(q_x);
	assign hash_sum = HASH_DIV_W'(q_x) * HASH_DIV_W'(HASH_MUL_X)
		+ HASH_DIV_W'(q_y) * HASH_DIV_W'(HASH_MUL_Y);

	// A hash length of zero or beyond the table is taken as the full table.
	assign modulus = ((hlen_q == '0) || (32'(hlen_q) > HASH_DEPTH))
		? MOD_W'(HASH_DEPTH) : MOD_W'(hlen_q);
	assign mod_start = cmd_fire && (cmd.data.opcode == OP_QUERY) && !q_neg;

	shl_hash_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (hash_sum),
		.modulus  (modulus),
		.res      (mod_res)
	);

	// The bucket read is issued the cycle the remainder is ready.
	shl_bucket_store u_bkt (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (bkt_wr),
		.rd_en    (mod_res.done),
		.rd_addr  (mod_res.rem),
		.rd_data  (bkt_rd),
		.clearing (clearing)
	);

	// Bucket range: the scan runs over [first, first + size), clipped to
	// the end of the cell table.
	assign bkt_first = SLOT_W'(bkt_rd.first);
	assign bkt_sum   = BKT_SUM_W'(bkt_rd.first) + BKT_SUM_W'(bkt_rd.size);
	assign bkt_stop  = (bkt_sum > BKT_SUM_W'(CELL_DEPTH))
		? SLOT_W'(CELL_DEPTH) : SLOT_W'(bkt_sum);
	assign slot_next = slot_q + 1'b1;

	// The cell read is issued in the cycle before the compare: the first slot while
	// the bucket entry is on the read port, then the slot after the one
	// being compared.
	assign cell_rd_en   = (state_q == ST_BKT) || (state_q == ST_SCAN);
	assign cell_rd_addr = (state_q == ST_BKT) ? CELL_AW'(bkt_first)
		: CELL_AW'(slot_next);

	shl_cell_store u_cell (
		.clk     (clk),
		.wr      (cell_wr),
		.rd_en   (cell_rd_en),
		.rd_addr (cell_rd_addr),
		.rd_data (cell_rd)
	);

	assign cell_hit  = (cell_rd.key == key_q);
	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || rsp.ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_fire && (cmd.data.opcode == OP_QUERY)) begin
					state_d = q_neg ? ST_EMIT : ST_HASH;
				end
			end
			ST_HASH: begin
				if (mod_res.done) begin
					state_d = ST_BKT;
				end
			end
			ST_BKT: begin
				if (bkt_rd.empty || (bkt_first >= bkt_stop)) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cell_hit || (slot_next >= stop_q)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cpr_q       <= CPR_RESET;
			hlen_q      <= HLEN_RESET;
		end else begin
			state_q <= state_d;
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_CELLS_PER_ROW: cpr_q  <= cfg_data;
					CFG_HASH_LENGTH:   hlen_q <= HLEN_W'(cfg_data);
					default: begin
					end
				endcase
			end
		end
	end

	// Datapath registers of the query in flight and the output register.
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			key_q <= key_d;
			res_q <= MISS_RESULT;
		end
		if (state_q == ST_BKT) begin
			slot_q <= bkt_first;
			stop_q <= bkt_stop;
		end
		if (state_q == ST_SCAN) begin
			slot_q <= slot_next;
			if (cell_hit) begin
				res_q.found       <= 1'b1;
				res_q.range_begin <= RANGE_W'(cell_rd.first);
				res_q.range_end   <= RANGE_W'(cell_rd.first) + RANGE_W'(cell_rd.count);
			end
		end
		if (emit_load) begin
			out_q <= res_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// The remainder only finishes for a query waiting on it.
	a_mod_done_in_hash: assert property (@(posedge clk) disable iff (!arst_n)
		mod_res.done |-> (state_q == ST_HASH))
		else $error("remainder finished outside the hash state");

	// The slot under compare always lies inside the bucket's range.
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (slot_q < stop_q))
		else $error("cell scan ran past the bucket range");

	// A finished query must not leave while the previous response is unread.
	a_emit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EMIT) && out_valid_q && !rsp.ready) |=> (state_q == ST_EMIT))
		else $error("response dropped while output register busy");

	// No table write may race the clearing pass.
	a_no_write_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> (!bkt_wr.en && !cell_wr.en))
		else $error("table write during bucket clearing pass");

endmodule
